### rtl/core/ccrp_pkg.sv
// Shared types and constants of the channel concatenation rotation planner.
// Used by the configuration, divider, sequencer and top-level modules.
`default_nettype none

package ccrp_pkg;

  localparam int MaxInputsDefault = 8;
  localparam int SlotCountDefault = 32768;

  // shared divider geometry
  localparam int DIV_DW = 37;  // dividend and quotient width
  localparam int DIV_VW = 16;  // divisor and remainder width
  localparam int DIV_CW = 6;   // iteration count width

  typedef enum logic [2:0] {
    CFG_CHANNELS_PER_CT = 3'd0,
    CFG_SKIP_ROWS       = 3'd1,
    CFG_SKIP_COLS       = 3'd2,
    CFG_SHAPE_ROWS      = 3'd3,
    CFG_SHAPE_COLS      = 3'd4,
    CFG_COUNTS_LOW      = 3'd5,
    CFG_COUNTS_HIGH     = 3'd6,
    CFG_INPUT_COUNT     = 3'd7
  } cfg_idx_e;

  // clamped configuration seen by the sequencer
  typedef struct packed {
    logic [12:0]  cpc;
    logic [4:0]   sr;
    logic [4:0]   sc;
    logic [8:0]   hr;
    logic [8:0]   hc;
    logic [127:0] counts;
    logic [3:0]   n;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic [DIV_VW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        out_of_range;
    logic [2:0]  source_input;
    logic [15:0] source_ct;
    logic [14:0] source_slot_base;
    logic [18:0] output_ct;
    logic [11:0] output_position;
    logic [14:0] dest_slot_base;
    logic [15:0] rotation_step;
    logic        first_of_ct;
    logic        last_in_ct;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/ccrp_cfg.sv
// Configuration register file with clamping of zero and oversized values.
// Depends on ccrp_pkg.
`default_nettype none

module ccrp_cfg import ccrp_pkg::*; #(
  parameter int MAX_INPUTS = MaxInputsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output cfg_t             cfg_o
);

  logic [12:0] cpc_q;
  logic [4:0]  sr_q;
  logic [4:0]  sc_q;
  logic [8:0]  hr_q;
  logic [8:0]  hc_q;
  logic [63:0] cnt_lo_q;
  logic [63:0] cnt_hi_q;
  logic [3:0]  n_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpc_q    <= 13'd1;
      sr_q     <= 5'd1;
      sc_q     <= 5'd1;
      hr_q     <= 9'd1;
      hc_q     <= 9'd1;
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
      n_q      <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHANNELS_PER_CT: cpc_q    <= cfg_data_i[12:0];
        CFG_SKIP_ROWS:       sr_q     <= cfg_data_i[4:0];
        CFG_SKIP_COLS:       sc_q     <= cfg_data_i[4:0];
        CFG_SHAPE_ROWS:      hr_q     <= cfg_data_i[8:0];
        CFG_SHAPE_COLS:      hc_q     <= cfg_data_i[8:0];
        CFG_COUNTS_LOW:      cnt_lo_q <= cfg_data_i;
        CFG_COUNTS_HIGH:     cnt_hi_q <= cfg_data_i;
        CFG_INPUT_COUNT:     n_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.cpc    = (cpc_q == '0) ? 13'd1 : ((cpc_q > 13'd4096) ? 13'd4096 : cpc_q);
    cfg_o.sr     = (sr_q == '0) ? 5'd1 : ((sr_q > 5'd16) ? 5'd16 : sr_q);
    cfg_o.sc     = (sc_q == '0) ? 5'd1 : ((sc_q > 5'd16) ? 5'd16 : sc_q);
    cfg_o.hr     = (hr_q == '0) ? 9'd1 : ((hr_q > 9'd256) ? 9'd256 : hr_q);
    cfg_o.hc     = (hc_q == '0) ? 9'd1 : ((hc_q > 9'd256) ? 9'd256 : hc_q);
    cfg_o.counts = {cnt_hi_q, cnt_lo_q};
    cfg_o.n      = (n_q == '0) ? 4'd1 :
                   ((n_q > 4'(MAX_INPUTS)) ? 4'(MAX_INPUTS) : n_q);
  end

endmodule

`default_nettype wire

### rtl/core/ccrp_div.sv
// Shared restoring divider, one quotient bit per cycle over a chosen bit count.
// Depends on ccrp_pkg.
`default_nettype none

module ccrp_div import ccrp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  div_req_t  req_i,
  output div_rsp_t  rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW-1:0] q_q;
  logic [DIV_VW-1:0] rem_q;
  logic [DIV_VW-1:0] dvs_q;
  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   diff;
  logic              ge;

  assign trial = {rem_q, q_q[DIV_DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q   <= req_i.dividend << (DIV_CW'(DIV_DW) - req_i.nbits);
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
      q_q   <= {q_q[DIV_DW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

### rtl/core/ccrp_ctrl.sv
// Sequencer: input scan, shared multiplier, divider scheduling and result build.
// Depends on ccrp_pkg; drives the shared divider ccrp_div.
`default_nettype none

module ccrp_ctrl import ccrp_pkg::*; #(
  parameter int MAX_INPUTS = MaxInputsDefault,
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cfg_t             cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [18:0] in_g_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output res_t             res_o,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i
);

  localparam int IW = $clog2(MAX_INPUTS);
  localparam logic [DIV_CW-1:0] NbG    = DIV_CW'(19);
  localparam logic [DIV_CW-1:0] NbL    = DIV_CW'(16);
  localparam logic [DIV_CW-1:0] NbBlk  = DIV_CW'(12);
  localparam logic [DIV_CW-1:0] NbOff  = DIV_CW'(8);
  localparam logic [DIV_DW-1:0] SlotMask = DIV_DW'(SLOT_COUNT - 1);

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_SCAN    = 16'h0002,
    ST_CHECK   = 16'h0004,
    ST_MUL_PB  = 16'h0008,
    ST_MUL_HS  = 16'h0010,
    ST_MUL_ST  = 16'h0020,
    ST_MUL_BS  = 16'h0040,
    ST_DIV_G   = 16'h0080,
    ST_DIV_L   = 16'h0100,
    ST_DIV_BLK = 16'h0200,
    ST_DIV_OFF = 16'h0400,
    ST_MUL_BLK = 16'h0800,
    ST_MUL_CX  = 16'h1000,
    ST_SUM     = 16'h2000,
    ST_WRAP    = 16'h4000,
    ST_DONE    = 16'h8000
  } state_e;

  state_e         state_q, state_d;
  logic           issued_q, issued_d;
  logic           side_q, side_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           found_q, found_d;
  logic           is_div;
  logic           is_mul;
  logic [IW-1:0]  n_last;
  logic [15:0]    count_sel;

  logic [18:0] g_q, local_q, total_q, octs_q;
  logic [IW-1:0] src_q;
  logic        oor_q;
  logic [8:0]  per_block_q;
  logic [12:0] hrsr_q, stride_q;
  logic [24:0] bsize_q;
  logic [37:0] prod_q;
  logic [24:0] mul_a;
  logic [12:0] mul_b;
  logic [37:0] mul_p;
  logic [11:0] pos_q, lpos_q, blk_q;
  logic [15:0] sct_q;
  logic [7:0]  off_q;
  logic [3:0]  cx_q, cy_q;
  logic [DIV_DW-1:0] p1_q, base_q;
  logic [14:0] sbase_q, dbase_q;

  assign n_last    = IW'(cfg_i.n - 4'd1);
  assign count_sel = cfg_i.counts[idx_q*16 +: 16];
  assign is_div    = state_q inside {ST_DIV_G, ST_DIV_L, ST_DIV_BLK, ST_DIV_OFF};
  assign is_mul    = state_q inside {ST_MUL_PB, ST_MUL_HS, ST_MUL_ST, ST_MUL_BS,
                                     ST_MUL_BLK, ST_MUL_CX};

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    side_d   = side_q;
    idx_d    = idx_q;
    found_d  = found_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (!found_q && (local_q < 19'(count_sel))) found_d = 1'b1;
        if (idx_q == n_last) state_d = ST_CHECK;
      end
      ST_CHECK:  state_d = (g_q >= total_q) ? ST_DONE : ST_MUL_PB;
      ST_MUL_PB: state_d = ST_MUL_HS;
      ST_MUL_HS: state_d = ST_MUL_ST;
      ST_MUL_ST: state_d = ST_MUL_BS;
      ST_MUL_BS: state_d = ST_DIV_G;
      ST_DIV_G, ST_DIV_L, ST_DIV_BLK, ST_DIV_OFF: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (div_rsp_i.done) begin
          issued_d = 1'b0;
          case (state_q)
            ST_DIV_G: state_d = ST_DIV_L;
            ST_DIV_L: begin
              state_d = ST_DIV_BLK;
              side_d  = 1'b0;
            end
            ST_DIV_BLK: state_d = ST_DIV_OFF;
            default:    state_d = ST_MUL_BLK;
          endcase
        end
      end
      ST_MUL_BLK: state_d = ST_MUL_CX;
      ST_MUL_CX:  state_d = ST_SUM;
      ST_SUM:     state_d = ST_WRAP;
      ST_WRAP: begin
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = ST_DIV_BLK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      side_q   <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      side_q   <= side_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_PB: begin
        mul_a = 25'(cfg_i.sr);
        mul_b = 13'(cfg_i.sc);
      end
      ST_MUL_HS: begin
        mul_a = 25'(cfg_i.hr);
        mul_b = 13'(cfg_i.sr);
      end
      ST_MUL_ST: begin
        mul_a = 25'(cfg_i.hc);
        mul_b = 13'(cfg_i.sc);
      end
      ST_MUL_BS: begin
        mul_a = 25'(prod_q[12:0]);
        mul_b = hrsr_q;
      end
      ST_MUL_BLK: begin
        mul_a = bsize_q;
        mul_b = 13'(blk_q);
      end
      ST_MUL_CX: begin
        mul_a = 25'(stride_q);
        mul_b = 13'(cx_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider operands
  always_comb begin
    div_req_o.start    = is_div && !issued_q;
    div_req_o.dividend = '0;
    div_req_o.divisor  = 16'(cfg_i.cpc);
    div_req_o.nbits    = NbG;
    case (state_q)
      ST_DIV_G: div_req_o.dividend = DIV_DW'(g_q);
      ST_DIV_L: begin
        div_req_o.dividend = DIV_DW'(local_q[15:0]);
        div_req_o.nbits    = NbL;
      end
      ST_DIV_BLK: begin
        div_req_o.dividend = DIV_DW'(side_q ? pos_q : lpos_q);
        div_req_o.divisor  = 16'(per_block_q);
        div_req_o.nbits    = NbBlk;
      end
      ST_DIV_OFF: begin
        div_req_o.dividend = DIV_DW'(off_q);
        div_req_o.divisor  = 16'(cfg_i.sc);
        div_req_o.nbits    = NbOff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (is_mul) prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        g_q     <= in_g_i;
        local_q <= in_g_i;
        total_q <= '0;
        src_q   <= '0;
      end
      ST_SCAN: begin
        total_q <= total_q + 19'(count_sel);
        if (!found_q) begin
          if (local_q < 19'(count_sel)) src_q <= idx_q;
          else local_q <= local_q - 19'(count_sel);
        end
      end
      ST_CHECK:  oor_q       <= g_q >= total_q;
      ST_MUL_HS: per_block_q <= prod_q[8:0];
      ST_MUL_ST: hrsr_q      <= prod_q[12:0];
      ST_MUL_BS: stride_q    <= prod_q[12:0];
      ST_DIV_G: begin
        bsize_q <= prod_q[24:0];
        if (div_rsp_i.done) begin
          octs_q <= div_rsp_i.quot[18:0];
          pos_q  <= div_rsp_i.rem[11:0];
        end
      end
      ST_DIV_L: begin
        if (div_rsp_i.done) begin
          sct_q  <= div_rsp_i.quot[15:0];
          lpos_q <= div_rsp_i.rem[11:0];
        end
      end
      ST_DIV_BLK: begin
        if (div_rsp_i.done) begin
          blk_q <= div_rsp_i.quot[11:0];
          off_q <= div_rsp_i.rem[7:0];
        end
      end
      ST_DIV_OFF: begin
        if (div_rsp_i.done) begin
          cx_q <= div_rsp_i.quot[3:0];
          cy_q <= div_rsp_i.rem[3:0];
        end
      end
      ST_MUL_CX: p1_q   <= prod_q[DIV_DW-1:0];
      ST_SUM:    base_q <= p1_q + prod_q[DIV_DW-1:0] + DIV_DW'(cy_q);
      ST_WRAP: begin
        if (!side_q) sbase_q <= 15'(base_q & SlotMask);
        else dbase_q <= 15'(base_q & SlotMask);
      end
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;

  always_comb begin
    res_o = '0;
    if (oor_q) begin
      res_o.out_of_range = 1'b1;
    end else begin
      res_o.source_input     = 3'(src_q);
      res_o.source_ct        = sct_q;
      res_o.source_slot_base = sbase_q;
      res_o.output_ct        = octs_q;
      res_o.output_position  = pos_q;
      res_o.dest_slot_base   = dbase_q;
      res_o.rotation_step    = {1'b0, sbase_q} - {1'b0, dbase_q};
      res_o.first_of_ct      = pos_q == '0;
      res_o.last_in_ct       = (pos_q == 12'(cfg_i.cpc - 13'd1)) ||
                               (g_q == total_q - 19'd1);
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == ST_DIV_G || state_q == ST_DIV_L ||
                        state_q == ST_DIV_BLK || state_q == ST_DIV_OFF))
    else $error("divider result outside a division step");

  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_of_range) |->
      (res_o.source_ct == '0 && res_o.output_ct == '0 &&
       res_o.rotation_step == '0 && !res_o.first_of_ct && !res_o.last_in_ct))
    else $error("out-of-range result carries nonzero fields");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.out_of_range) |->
      (13'(res_o.output_position) < cfg_i.cpc))
    else $error("output position not below channels per ciphertext");

  a_wrap_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRAP && side_q) |=> (state_q == ST_DONE))
    else $error("destination base done but result not presented");

  a_slot_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SLOT_COUNT & (SLOT_COUNT - 1)) == 0)
    else $error("slot count is not a power of two");
`endif

endmodule

`default_nettype wire

### rtl/core/channel_concat_rotation_planner_top.sv
// Top level of the channel concatenation rotation planner.
// Depends on ccrp_pkg, ccrp_cfg, ccrp_div and ccrp_ctrl.
`default_nettype none

// One global channel index goes in, one plan entry comes out. The block walks
// the per-input channel counts one input per cycle, then runs all divisions
// (channel / channels_per_ct, block and offset splits) through one shared
// bit-serial divider and all products through one shared multiplier; the slot
// wrap is a mask, so SLOT_COUNT must be a power of two. The divider produces
// one quotient bit per cycle; an out-of-range item skips the products and
// divisions and goes from the range check straight to the result register.
// The input side is ready only between items, while a finished result can
// wait in the output register.
module channel_concat_rotation_planner_top import ccrp_pkg::*; #(
  parameter int MAX_INPUTS = MaxInputsDefault,
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // global_channel [18:0], zero fill [23:19]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // source_input [2:0], source_ct [18:3], source_slot_base [33:19],
  // output_ct [52:34], output_position [64:53], dest_slot_base [79:65],
  // rotation_step [95:80]
  output logic [95:0]      m_axis_tdata,
  // out_of_range [0], first_of_ct [1]
  output logic [1:0]       m_axis_tuser,
  // last_in_ct
  output logic             m_axis_tlast
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_q;
  res_t     out_q;

  ccrp_cfg #(
    .MAX_INPUTS(MAX_INPUTS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ccrp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  ccrp_ctrl #(
    .MAX_INPUTS(MAX_INPUTS),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_g_i     (s_axis_tdata[18:0]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.rotation_step, out_q.dest_slot_base,
                          out_q.output_position, out_q.output_ct,
                          out_q.source_slot_base, out_q.source_ct,
                          out_q.source_input};
  assign m_axis_tuser  = {out_q.first_of_ct, out_q.out_of_range};
  assign m_axis_tlast  = out_q.last_in_ct;

endmodule

`default_nettype wire
